>>> rtl/easing_curve_tween_unit_defines.svh
// Assertion macros shared by the tween unit RTL.
`ifndef EASING_CURVE_TWEEN_UNIT_DEFINES_SVH
`define EASING_CURVE_TWEEN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ECT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ECT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ect_pkg.sv
// Types and constants shared by the tween unit modules.
`timescale 1ns / 1ps
`default_nettype none

package ect_pkg;

  localparam int VALUE_W    = 16;
  localparam int TIME_W     = 16;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 2'd3;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Curve codes.
  localparam logic [MODE_W-1:0] MODE_LINEAR       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_IN           = 4'd1;
  localparam logic [MODE_W-1:0] MODE_OUT          = 4'd2;
  localparam logic [MODE_W-1:0] MODE_INOUT        = 4'd3;
  localparam logic [MODE_W-1:0] MODE_OUTIN        = 4'd4;
  localparam logic [MODE_W-1:0] MODE_BACKIN       = 4'd5;
  localparam logic [MODE_W-1:0] MODE_OUTBACK      = 4'd6;
  localparam logic [MODE_W-1:0] MODE_OUTELASTIC   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_INELASTIC    = 4'd8;
  localparam logic [MODE_W-1:0] MODE_OUT_BOUNCE   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_IN_BOUNCE    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_INOUT_BOUNCE = 4'd11;
  localparam logic [MODE_W-1:0] MODE_COUNT        = 4'd12;

  // Operand selections of the shared multiplier.
  localparam int MUL_SEL_W = 3;
  localparam logic [MUL_SEL_W-1:0] MUL_TS = 3'd0;
  localparam logic [MUL_SEL_W-1:0] MUL_TC = 3'd1;
  localparam logic [MUL_SEL_W-1:0] MUL_T4 = 3'd2;
  localparam logic [MUL_SEL_W-1:0] MUL_T5 = 3'd3;
  localparam logic [MUL_SEL_W-1:0] MUL_OB = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] time_increment;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current_value;
    logic                      running;
    logic                      just_finished;
  } out_item_t;

  typedef struct packed {
    logic                 accept;
    logic                 div_step;
    logic                 barg;
    logic                 bw;
    logic                 mul_step;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 poly;
    logic                 scale;
    logic                 sum;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic need_curve;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ect_datapath.sv
// Datapath: registers, divider, shared multiplier, curve and output stage.
`timescale 1ns / 1ps
`default_nettype none

module ect_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  input  wire  [ect_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [ect_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  ect_pkg::in_item_t                    in_data_i,
  input  wire                                  out_ready_i,
  input  ect_pkg::cmd_t                        cmd_i,
  output ect_pkg::sts_t                        sts_o,
  output logic                                 out_valid_o,
  output ect_pkg::out_item_t                   out_data_o
);

  localparam int TW  = ect_pkg::TIME_W;
  localparam int VW  = ect_pkg::VALUE_W;
  localparam int F   = FRAC_BITS;
  localparam int UW  = F + 1;
  localparam int MW  = F + 3;
  localparam int WW  = UW + 6;
  localparam int PW  = F + 12;
  localparam int CVW = VW + 1;
  localparam int SPW = CVW + PW;
  localparam int SHW = SPW - F;

  localparam logic [UW-1:0]          ONE_U = {1'b1, {F{1'b0}}};
  localparam logic signed [WW-1:0]   K4    = WW'(4 * (1 << F));
  localparam logic signed [WW-1:0]   K6    = WW'(6 * (1 << F));
  localparam logic signed [WW-1:0]   K8    = WW'(8 * (1 << F));
  localparam logic signed [WW-1:0]   K9    = WW'(9 * (1 << F));
  localparam logic signed [WW-1:0]   K10   = WW'(10 * (1 << F));
  localparam logic signed [WW-1:0]   K21   = WW'(21 * (1 << F));
  localparam logic [UW-1:0]          OFS1  = UW'(3 << (F - 2));
  localparam logic [UW-1:0]          OFS2  = UW'(15 << (F - 4));
  localparam logic [UW-1:0]          OFS3  = UW'(63 << (F - 6));
  localparam logic signed [SPW-1:0]  HALF  = SPW'(1) << (F - 1);
  localparam logic signed [SHW:0]    VMAX  = (SHW+1)'((1 << (VW - 1)) - 1);
  localparam logic signed [SHW:0]    VMIN  = -VMAX - (SHW+1)'(1);

  // Configuration registers.
  logic [ect_pkg::MODE_W-1:0] mode_q;
  logic [TW-1:0]              dur_q;
  logic signed [VW-1:0]       beg_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      dur_q  <= '0;
      beg_q  <= '0;
      end_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ect_pkg::REG_MODE:     mode_q <= cfg_data_i[ect_pkg::MODE_W-1:0];
        ect_pkg::REG_DURATION: dur_q  <= cfg_data_i[TW-1:0];
        ect_pkg::REG_BEGIN:    beg_q  <= cfg_data_i[VW-1:0];
        ect_pkg::REG_END:      end_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  logic [TW-1:0]        elapsed_q;
  logic                 active_q, fin_q;
  logic signed [VW-1:0] held_q;
  logic signed [VW-1:0] result_w;

  // Time accumulation and the finishing test for a tick.
  logic [TW:0] sum_w;
  logic        finish_w;
  assign sum_w    = {1'b0, elapsed_q} + {1'b0, in_data_i.time_increment};
  assign finish_w = (dur_q == '0) || (sum_w > {1'b0, dur_q});

  assign sts_o.need_curve = (in_data_i.kind == ect_pkg::KIND_TICK) && active_q && !finish_w;

  // Tween state, updated on the input transfer and at the final sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      active_q  <= 1'b0;
      fin_q     <= 1'b0;
      held_q    <= '0;
    end else if (cmd_i.accept) begin
      fin_q <= 1'b0;
      if (in_data_i.kind == ect_pkg::KIND_START) begin
        active_q  <= 1'b1;
        elapsed_q <= '0;
        held_q    <= beg_q;
      end else if (active_q) begin
        if (finish_w) begin
          elapsed_q <= dur_q;
          held_q    <= end_q;
          active_q  <= 1'b0;
          fin_q     <= 1'b1;
        end else begin
          elapsed_q <= sum_w[TW-1:0];
        end
      end
    end else if (cmd_i.sum) begin
      held_q <= result_w;
    end
  end

  // Restoring divider: one quotient bit of time/duration per step.
  logic [TW:0]   rem_q, r2_w;
  logic [F-1:0]  quo_q;
  logic          eq_q, ge_w;
  logic [UW-1:0] u_w;
  assign r2_w = {rem_q[TW-1:0], 1'b0};
  assign ge_w = r2_w >= {1'b0, dur_q};
  assign u_w  = eq_q ? ONE_U : {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q <= sum_w;
      quo_q <= '0;
      eq_q  <= (sum_w == {1'b0, dur_q});
    end else if (cmd_i.div_step) begin
      rem_q <= ge_w ? (r2_w - {1'b0, dur_q}) : r2_w;
      quo_q <= {quo_q[F-2:0], ge_w};
    end
  end

  // Bounce argument: mirrored or doubled position depending on the curve.
  logic [UW:0]   two_u_w;
  logic [UW-1:0] arg_d, arg_q;
  logic          half_lo_d, half_lo_q;
  assign two_u_w   = {u_w, 1'b0};
  assign half_lo_d = two_u_w < {1'b0, ONE_U};

  always_comb begin
    case (mode_q)
      ect_pkg::MODE_IN_BOUNCE:    arg_d = ONE_U - u_w;
      ect_pkg::MODE_INOUT_BOUNCE: arg_d = half_lo_d ? UW'({1'b0, ONE_U} - two_u_w)
                                                    : UW'(two_u_w - {1'b0, ONE_U});
      default:                    arg_d = u_w;
    endcase
  end

  // Bounce segment and the magnitude of its offset term.
  logic [UW+3:0]        x11_w;
  logic signed [WW-1:0] x11s_w, w_w;
  logic [1:0]           seg_d, seg_q;
  logic [MW-1:0]        wabs_q;
  assign x11_w  = (UW+4)'(arg_q) * (UW+4)'(11);
  assign x11s_w = $signed({2'b00, x11_w});

  always_comb begin
    if (x11s_w < K4) begin
      seg_d = 2'd0;
      w_w   = x11s_w;
    end else if (x11s_w < K8) begin
      seg_d = 2'd1;
      w_w   = x11s_w - K6;
    end else if (x11s_w < K10) begin
      seg_d = 2'd2;
      w_w   = x11s_w - K9;
    end else begin
      seg_d = 2'd3;
      w_w   = (x11s_w <<< 1) - K21;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.barg) begin
      arg_q     <= arg_d;
      half_lo_q <= half_lo_d;
    end
    if (cmd_i.bw) begin
      seg_q  <= seg_d;
      wabs_q <= MW'(w_w < 0 ? -w_w : w_w);
    end
  end

  // Shared multiplier for the powers of u and the bounce square.
  logic [UW-1:0]   ts_q, tc_q, t4_q, t5_q, ob_q;
  logic [MW-1:0]   ma_w, mb_w;
  logic [2*MW-1:0] prod_w;

  always_comb begin
    case (cmd_i.mul_sel)
      ect_pkg::MUL_TS: begin ma_w = MW'(u_w);  mb_w = MW'(u_w);  end
      ect_pkg::MUL_TC: begin ma_w = MW'(ts_q); mb_w = MW'(u_w);  end
      ect_pkg::MUL_T4: begin ma_w = MW'(ts_q); mb_w = MW'(ts_q); end
      ect_pkg::MUL_T5: begin ma_w = MW'(tc_q); mb_w = MW'(ts_q); end
      default:         begin ma_w = wabs_q;    mb_w = wabs_q;    end
    endcase
  end
  assign prod_w = (2*MW)'(ma_w) * (2*MW)'(mb_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      case (cmd_i.mul_sel)
        ect_pkg::MUL_TS: ts_q <= UW'(prod_w >> F);
        ect_pkg::MUL_TC: tc_q <= UW'(prod_w >> F);
        ect_pkg::MUL_T4: t4_q <= UW'(prod_w >> F);
        ect_pkg::MUL_T5: t5_q <= UW'(prod_w >> F);
        default: begin
          case (seg_q)
            2'd0:    ob_q <= UW'(prod_w >> (F + 4));
            2'd1:    ob_q <= UW'(prod_w >> (F + 4)) + OFS1;
            2'd2:    ob_q <= UW'(prod_w >> (F + 4)) + OFS2;
            default: ob_q <= UW'(prod_w >> (F + 6)) + OFS3;
          endcase
        end
      endcase
    end
  end

  // Curve value from the powers of u or the bounce term.
  logic signed [PW-1:0] su, sts, stc, st4, st5, sob, sone, p_d, p_q;
  assign su   = $signed(PW'(u_w));
  assign sts  = $signed(PW'(ts_q));
  assign stc  = $signed(PW'(tc_q));
  assign st4  = $signed(PW'(t4_q));
  assign st5  = $signed(PW'(t5_q));
  assign sob  = $signed(PW'(ob_q));
  assign sone = $signed(PW'(ONE_U));

  always_comb begin
    case (mode_q)
      ect_pkg::MODE_LINEAR:     p_d = su;
      ect_pkg::MODE_IN:         p_d = st4;
      ect_pkg::MODE_OUT:        p_d = PW'(-st4 + 4 * stc - 6 * sts + 4 * su);
      ect_pkg::MODE_INOUT:      p_d = PW'(6 * st5 - 15 * st4 + 10 * stc);
      ect_pkg::MODE_OUTIN:      p_d = PW'(6 * stc - 9 * sts + 4 * su);
      ect_pkg::MODE_BACKIN:     p_d = PW'(2 * st4 + 2 * stc - 3 * sts);
      ect_pkg::MODE_OUTBACK:    p_d = PW'(-2 * st4 + 10 * stc - 15 * sts + 8 * su);
      ect_pkg::MODE_OUTELASTIC: p_d = PW'(56 * st5 - 175 * st4 + 200 * stc - 100 * sts
                                          + 20 * su);
      ect_pkg::MODE_INELASTIC:  p_d = PW'(56 * st5 - 105 * st4 + 60 * stc - 10 * sts);
      ect_pkg::MODE_OUT_BOUNCE: p_d = sob;
      ect_pkg::MODE_IN_BOUNCE:  p_d = sone - sob;
      ect_pkg::MODE_INOUT_BOUNCE: p_d = half_lo_q ? ((sone - sob) >>> 1)
                                                  : ((sob + sone) >>> 1);
      default:                  p_d = '0;
    endcase
  end

  // Scaling by the change, with rounding to nearest.
  logic signed [CVW-1:0] chg_w;
  logic signed [SPW-1:0] scale_q;
  assign chg_w = $signed({end_q[VW-1], end_q}) - $signed({beg_q[VW-1], beg_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.poly)  p_q     <= p_d;
    if (cmd_i.scale) scale_q <= SPW'(chg_w) * SPW'(p_q) + HALF;
  end

  // Offset by the begin value and saturate.
  logic signed [SHW-1:0] sh_w;
  logic signed [SHW:0]   tot_w;
  assign sh_w  = SHW'(scale_q >>> F);
  assign tot_w = $signed({sh_w[SHW-1], sh_w}) + (SHW+1)'(beg_q);

  always_comb begin
    if (mode_q >= ect_pkg::MODE_COUNT) begin
      result_w = beg_q;
    end else if (tot_w > VMAX) begin
      result_w = VW'(VMAX);
    end else if (tot_w < VMIN) begin
      result_w = VW'(VMIN);
    end else begin
      result_w = VW'(tot_w);
    end
  end

  // Output register.
  logic      out_valid_q;
  ect_pkg::out_item_t out_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.current_value <= held_q;
      out_q.running       <= active_q;
      out_q.just_finished <= fin_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ect_controller.sv
// Controller: sequences one item through divider, multiplier and output.
`timescale 1ns / 1ps
`default_nettype none

module ect_controller #(
  parameter int FRAC_BITS = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  ect_pkg::sts_t  sts_i,
  output ect_pkg::cmd_t  cmd_o
);

  localparam int CW = $clog2(FRAC_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_BARG  = 4'd2;
  localparam logic [3:0] S_BW    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_POLY  = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]    state_d, state_q;
  logic [CW-1:0] cnt_d, cnt_q;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.mul_sel = cnt_q[ect_pkg::MUL_SEL_W-1:0];
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = sts_i.need_curve ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CW'(FRAC_BITS - 1)) begin
          cnt_d   = '0;
          state_d = S_BARG;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_BARG: begin
        cmd_o.barg = 1'b1;
        state_d    = S_BW;
      end
      S_BW: begin
        cmd_o.bw = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == CW'(ect_pkg::MUL_OB)) begin
          state_d = S_POLY;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_POLY: begin
        cmd_o.poly = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/easing_curve_tween_unit.sv
// Top level of the easing curve tween unit.
//
// Usage: configure curve, duration, begin and end values through the
// configuration channel (always ready) while the unit is idle. Each input
// transfer is either a start, which re-arms the tween, or a tick, which
// advances the elapsed time by its increment. Every input item yields
// exactly one result item: the eased value, the running flag and a
// just-finished pulse on the tick that ends the tween.
// Sequencing: one item is in flight at a time. A start, an idle tick or a
// finishing tick goes straight from its transfer to the done state, which
// loads its result into the output register. A tick inside the tween runs
// the restoring divider over FRAC_BITS quotient bits, then bounce set-up,
// five passes of the shared multiplier, curve, scale, sum and the done state.
// Reset clears configuration, tween state and output valid; the tween goes idle with value zero.
// The result waits in an output register; while the receiver stalls, the
// unit can take and work on the next item, then holds in the done state,
// taking no new input until the waiting result has been transferred.
`timescale 1ns / 1ps
`default_nettype none
`include "easing_curve_tween_unit_defines.svh"

module easing_curve_tween_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [ect_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [ect_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  ect_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output ect_pkg::out_item_t              out_data_o
);

  ect_pkg::cmd_t cmd;
  ect_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  ect_controller #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  ect_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Checks on the sequencing.
  `ECT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "taken while busy")
  `ECT_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free, "result overwritten")
  `ECT_ASSERT_IMPL(a_fin_idle, out_valid_o && out_data_o.just_finished, !out_data_o.running, "flags clash")

endmodule

`default_nettype wire
